[rtl/albr_pkg.sv]
// Package for the ambient light backlight ramp: types, constants, ladder map.
package albr_pkg;

	localparam int LEVEL_W   = 7;
	localparam int READING_W = 16;
	localparam int COUNT_W   = 8;
	localparam int TOL_W     = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;
	localparam int LADDER_STEPS = 10;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 7'd100;
	localparam logic [COUNT_W-1:0] RESTART_COUNT = 8'd5;

	// Item operation codes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALS_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_STEPS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_COUNT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD   = 3'd5;

	// Ladder edges, brightest first, with the level each maps to
	localparam logic [READING_W-1:0] LADDER_EDGE [LADDER_STEPS] = '{
		16'h5034, 16'h4620, 16'h3C26, 16'h3220, 16'h2189,
		16'h1E13, 16'h149A, 16'h0F73, 16'h0A4D, 16'h0834
	};
	localparam logic [LEVEL_W-1:0] LADDER_LEVEL [LADDER_STEPS] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60,
		7'd50, 7'd40, 7'd30, 7'd20, 7'd10
	};

	typedef struct packed {
		logic                 op;
		logic [READING_W-1:0] sample;
		logic [LEVEL_W-1:0]   start_level;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [LEVEL_W-1:0] target_level;
		logic               level_changed;
		logic               reading_settled;
	} out_item_t;

	typedef struct packed {
		logic               als_enable;
		logic [LEVEL_W-1:0] offset_steps;
		logic [COUNT_W-1:0] sample_period;
		logic [TOL_W-1:0]   tolerance;
		logic [COUNT_W-1:0] sense_stable_count;
		logic [COUNT_W-1:0] ramp_period;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0]   sample_cnt;
		logic [COUNT_W-1:0]   stable_cnt;
		logic [COUNT_W-1:0]   ramp_cnt;
		logic [READING_W-1:0] window_ref;
		logic [LEVEL_W-1:0]   target;
		logic [LEVEL_W-1:0]   level;
	} state_t;

	localparam cfg_t CFG_RESET = '{
		als_enable:         1'b0,
		offset_steps:       7'd0,
		sample_period:      8'd200,
		tolerance:          15'd255,
		sense_stable_count: 8'd2,
		ramp_period:        8'd25
	};

	localparam state_t STATE_RESET = '{
		sample_cnt: 8'd200,
		stable_cnt: 8'd2,
		ramp_cnt:   8'd25,
		window_ref: 16'd0,
		target:     7'd0,
		level:      7'd0
	};

	// First edge strictly exceeded wins; a reading at or below the lowest edge maps to 0
	function automatic logic [LEVEL_W-1:0] ladder_map(input logic [READING_W-1:0] r);
		logic [LEVEL_W-1:0] m;
		m = '0;
		for (int i = LADDER_STEPS - 1; i >= 0; i--) begin
			if (r > LADDER_EDGE[i])
				m = LADDER_LEVEL[i];
		end
		return m;
	endfunction

endpackage

[rtl/albr_step.sv]
// Next-state and result logic for one item of the backlight ramp.
module albr_step (
	input  albr_pkg::state_t   cur,
	input  albr_pkg::cfg_t     cfg,
	input  albr_pkg::in_item_t item,
	output albr_pkg::state_t   nxt,
	output albr_pkg::out_item_t res
);

	logic                           tick_en;
	logic [albr_pkg::COUNT_W-1:0]   sample_dec;
	logic [albr_pkg::COUNT_W-1:0]   stable_dec;
	logic [albr_pkg::COUNT_W-1:0]   ramp_dec;
	logic                           sample_fire;
	logic                           ramp_fire;
	logic [albr_pkg::READING_W-1:0] clamp_lo;
	logic [albr_pkg::READING_W-1:0] clamp_hi;
	logic [albr_pkg::READING_W-1:0] clamped;
	logic [albr_pkg::READING_W:0]   ref_plus_tol;
	logic [albr_pkg::READING_W:0]   smp_plus_tol;
	logic                           in_window;
	logic                           settle;
	logic [albr_pkg::LEVEL_W:0]     mapped_sum;
	logic [albr_pkg::LEVEL_W-1:0]   mapped_sat;
	logic [albr_pkg::LEVEL_W-1:0]   target_new;
	logic [albr_pkg::LEVEL_W-1:0]   start_sat;
	logic                           step_up;
	logic                           step_dn;

	assign tick_en    = (item.op == albr_pkg::OP_TICK) && cfg.als_enable;
	assign sample_dec = cur.sample_cnt - albr_pkg::COUNT_W'(1);
	assign stable_dec = cur.stable_cnt - albr_pkg::COUNT_W'(1);
	assign ramp_dec   = cur.ramp_cnt - albr_pkg::COUNT_W'(1);
	assign sample_fire = tick_en && (sample_dec == '0);
	assign ramp_fire   = tick_en && (ramp_dec == '0);

	// clamp to [tol, 65535 - tol]
	assign clamp_lo = {1'b0, cfg.tolerance};
	assign clamp_hi = {albr_pkg::READING_W{1'b1}} - {1'b0, cfg.tolerance};

	always_comb begin
		if (item.sample < clamp_lo)
			clamped = clamp_lo;
		else if (item.sample > clamp_hi)
			clamped = clamp_hi;
		else
			clamped = item.sample;
	end

	// ref - tol <= s <= ref + tol, kept unsigned by moving tol across
	assign ref_plus_tol = {1'b0, cur.window_ref} + {2'b00, cfg.tolerance};
	assign smp_plus_tol = {1'b0, clamped} + {2'b00, cfg.tolerance};
	assign in_window    = (ref_plus_tol >= {1'b0, clamped}) &&
	                      (smp_plus_tol >= {1'b0, cur.window_ref});
	assign settle       = sample_fire && in_window && (stable_dec == '0);

	assign mapped_sum = {1'b0, albr_pkg::ladder_map(cur.window_ref)} +
	                    {1'b0, cfg.offset_steps};
	assign mapped_sat = (mapped_sum > {1'b0, albr_pkg::LEVEL_MAX}) ?
	                    albr_pkg::LEVEL_MAX : mapped_sum[albr_pkg::LEVEL_W-1:0];
	assign target_new = settle ? mapped_sat : cur.target;

	assign step_up = ramp_fire && (target_new > cur.level);
	assign step_dn = ramp_fire && (target_new < cur.level);

	assign start_sat = (item.start_level > albr_pkg::LEVEL_MAX) ?
	                   albr_pkg::LEVEL_MAX : item.start_level;

	always_comb begin
		nxt = cur;
		res.level_changed   = 1'b0;
		res.reading_settled = 1'b0;
		if (item.op == albr_pkg::OP_RESTART) begin
			nxt.sample_cnt = albr_pkg::RESTART_COUNT;
			nxt.stable_cnt = albr_pkg::RESTART_COUNT;
			nxt.ramp_cnt   = albr_pkg::RESTART_COUNT;
			nxt.target     = start_sat;
			nxt.level      = start_sat;
		end else if (tick_en) begin
			nxt.sample_cnt = sample_fire ? cfg.sample_period : sample_dec;
			if (sample_fire) begin
				if (!in_window) begin
					nxt.stable_cnt = cfg.sense_stable_count;
					nxt.window_ref = clamped;
				end else if (stable_dec == '0) begin
					nxt.stable_cnt = cfg.sense_stable_count;
				end else begin
					nxt.stable_cnt = stable_dec;
				end
			end
			nxt.target     = target_new;
			nxt.ramp_cnt   = ramp_fire ? cfg.ramp_period : ramp_dec;
			if (step_up)
				nxt.level = cur.level + albr_pkg::LEVEL_W'(1);
			else if (step_dn)
				nxt.level = cur.level - albr_pkg::LEVEL_W'(1);
			res.level_changed   = step_up || step_dn;
			res.reading_settled = settle;
		end
		res.level        = nxt.level;
		res.target_level = nxt.target;
	end

endmodule

[rtl/ambient_light_backlight_ramp.sv]
// Ambient light backlight ramp: top level with config registers and result register.
// Latency: a result is valid the cycle after its item transfer (one register stage).
// Throughput: one item per cycle while results are drained; the whole update is a single pass through albr_step.
// An item is taken whenever the result register is empty or is being drained this cycle.
// Reset (arst_n low, asynchronous): registers to their defaults, countdowns to
// 200/2/25, reference, target and level to 0, result register empty.
module ambient_light_backlight_ramp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item channel
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  albr_pkg::in_item_t                   item,
	// result channel
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output albr_pkg::out_item_t                  result,
	// config write port
	input  logic                                 cfg_we,
	input  logic [albr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [albr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	albr_pkg::cfg_t      cfg_q;
	albr_pkg::state_t    state_q;
	albr_pkg::state_t    state_nxt;
	albr_pkg::out_item_t res_nxt;
	albr_pkg::out_item_t result_q;
	logic                result_valid_q;
	logic                item_xfer;

	// Result register frees up in the same cycle it is drained
	assign item_ready = !result_valid_q || result_ready;
	assign item_xfer  = item_valid && item_ready;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Config decode; unknown indexes are dropped, data is cut to register width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= albr_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				albr_pkg::REG_ALS_ENABLE:    cfg_q.als_enable <= cfg_wdata[0];
				albr_pkg::REG_OFFSET_STEPS:  cfg_q.offset_steps <= cfg_wdata[albr_pkg::LEVEL_W-1:0];
				albr_pkg::REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_wdata[albr_pkg::COUNT_W-1:0];
				albr_pkg::REG_TOLERANCE:     cfg_q.tolerance <= cfg_wdata[albr_pkg::TOL_W-1:0];
				albr_pkg::REG_STABLE_COUNT:
					cfg_q.sense_stable_count <= cfg_wdata[albr_pkg::COUNT_W-1:0];
				albr_pkg::REG_RAMP_PERIOD:   cfg_q.ramp_period <= cfg_wdata[albr_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sampling, settling, ladder map and ramp step all resolve in one pass
	albr_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (item),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= albr_pkg::STATE_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (item_xfer)
				state_q <= state_nxt;
			if (item_xfer)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (item_xfer)
			result_q <= res_nxt;
	end

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.level <= albr_pkg::LEVEL_MAX) &&
		                   (result_q.target_level <= albr_pkg::LEVEL_MAX))
		else $error("level or target above maximum");

	a_restart_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(item_xfer && item.op == albr_pkg::OP_RESTART) |=>
		(result_q.level == result_q.target_level) && !result_q.level_changed &&
		!result_q.reading_settled)
		else $error("restart did not load level and target");

	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(item_xfer && item.op == albr_pkg::OP_TICK) |=>
		(result_q.level_changed == (result_q.level != $past(state_q.level))))
		else $error("level_changed disagrees with level movement");

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(item_xfer && item.op == albr_pkg::OP_TICK && !cfg_q.als_enable) |=>
		!result_q.level_changed && !result_q.reading_settled && $stable(state_q))
		else $error("tick changed state while dimming off");

endmodule
